// ===== sv/gtid_pkg.sv =====
package gtid_pkg;

  // Default table depth
  localparam int MAX_TARGETS_DEF = 16;

  // Field widths
  localparam int POS_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int SQ_W    = 2 * POS_W;
  localparam int DIST_W  = SQ_W + 1;

  // Input tdata / output tuser layout
  localparam int IN_DATA_W  = 2 * POS_W + TIME_W;
  localparam int OUT_DATA_W = ID_W;
  localparam int OUT_USER_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE      = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] MATCH_RADIUS_RST = 16'd300;
  localparam logic [SQ_W-1:0]  MATCH_LIMIT_RST  = 32'd90000;
  localparam logic [CFG_W-1:0] MAX_AGE_RST      = 16'd500;

  // Item kinds
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_DET   = 1'b1;

  localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
  localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

  // Controller to datapath
  typedef struct packed {
    logic frame_start;
    logic det_start;
    logic scan_step;
    logic commit;
  } gtid_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic prev_empty;
    logic out_busy;
  } gtid_stat_t;

endpackage

// ===== sv/gtid_ctrl.sv =====
module gtid_ctrl import gtid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_ready,
  input  gtid_stat_t stat,
  output gtid_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT1,
    S_WAIT2,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   accept;

  // Commands and next state
  always_comb begin
    in_ready        = (state == S_IDLE);
    accept          = in_valid && in_ready;
    cmd             = '0;
    cmd.frame_start = accept && (in_mode == MODE_FRAME);
    cmd.det_start   = accept && (in_mode == MODE_DET);
    cmd.scan_step   = (state == S_SCAN);
    cmd.commit      = (state == S_DONE) && !stat.out_busy;
    state_next      = state;
    case (state)
      S_IDLE: begin
        if (cmd.det_start) begin
          state_next = stat.prev_empty ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_WAIT1;
        end
      end
      S_WAIT1: state_next = S_WAIT2;
      S_WAIT2: state_next = S_DONE;
      S_DONE: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/gtid_dpath.sv =====
module gtid_dpath import gtid_pkg::*; #(
  parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gtid_cmd_t             cmd,
  output gtid_stat_t            stat,
  input  logic [POS_W-1:0]      in_x,
  input  logic [POS_W-1:0]      in_y,
  input  logic [TIME_W-1:0]     in_time,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       out_id,
  output logic                  out_new,
  output logic                  out_full
);

  localparam int IDX_W   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W   = $clog2(MAX_TARGETS + 1);
  localparam int ADDR_W  = IDX_W + 1;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int ENTRY_W = 2 * POS_W + ID_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TARGETS);

  // Configuration
  logic [SQ_W-1:0]  match_limit;
  logic [CFG_W-1:0] max_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_limit <= MATCH_LIMIT_RST;
      max_age     <= MAX_AGE_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_MATCH_RADIUS) begin
        match_limit <= SQ_W'(cfg_wdata) * SQ_W'(cfg_wdata);
      end else if (cfg_idx == REG_MAX_AGE) begin
        max_age <= cfg_wdata;
      end
    end
  end

  // Frame state: two table banks, previous one selected by ~cur_bank
  logic                   cur_bank;
  logic [CNT_W-1:0]       prev_count;
  logic [CNT_W-1:0]       cur_count;
  logic [TIME_W-1:0]      last_time;
  logic [ID_W-1:0]        next_ident;
  logic [MAX_TARGETS-1:0] prev_used;
  logic [TIME_W-1:0]      age;

  assign age = in_time - last_time;

  // Detection registers and scan pointer
  logic [POS_W-1:0] det_x, det_y;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] scan_idx_inc;

  assign scan_idx_inc = scan_idx + 1'b1;

  // Table memory: {x, y, id}
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               wr_en;
  logic [ID_W-1:0]    commit_id;

  assign rd_addr = {~cur_bank, scan_idx[IDX_W-1:0]};
  assign wr_addr = {cur_bank, cur_count[IDX_W-1:0]};
  assign wr_en   = cmd.commit && (cur_count < CNT_MAX);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {det_x, det_y, commit_id};
    end
    if (cmd.scan_step) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Stage 1: read issued
  logic             s1_valid, s1_used;
  logic [IDX_W-1:0] s1_idx;

  // Stage 2: squared distances
  logic             s2_valid, s2_used;
  logic [IDX_W-1:0] s2_idx;
  logic [ID_W-1:0]  s2_id;
  logic [SQ_W-1:0]  s2_sqx, s2_sqy;

  logic signed [POS_W:0] dx, dy;
  logic [POS_W-1:0]      mag_x, mag_y;
  logic [POS_W-1:0]      ent_x, ent_y;
  logic [ID_W-1:0]       ent_id;

  assign {ent_x, ent_y, ent_id} = rd_data;
  assign dx    = $signed({det_x[POS_W-1], det_x}) - $signed({ent_x[POS_W-1], ent_x});
  assign dy    = $signed({det_y[POS_W-1], det_y}) - $signed({ent_y[POS_W-1], ent_y});
  assign mag_x = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
  assign mag_y = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_step;
      s2_valid <= s1_valid;
    end
    s1_idx  <= scan_idx[IDX_W-1:0];
    s1_used <= prev_used[scan_idx[IDX_W-1:0]];
    s2_idx  <= s1_idx;
    s2_used <= s1_used;
    s2_id   <= ent_id;
    s2_sqx  <= SQ_W'(mag_x) * SQ_W'(mag_x);
    s2_sqy  <= SQ_W'(mag_y) * SQ_W'(mag_y);
  end

  // Stage 3: running minimum, ties keep the lower index
  logic [DIST_W-1:0] cand_dist, best;
  logic [IDX_W-1:0]  win_idx;
  logic [ID_W-1:0]   best_id;
  logic              found;

  assign cand_dist = {1'b0, s2_sqx} + {1'b0, s2_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.det_start) begin
      found <= 1'b0;
    end else if (s2_valid && !s2_used && (cand_dist < best)) begin
      found <= 1'b1;
    end
    if (cmd.det_start) begin
      best     <= {1'b0, match_limit};
      det_x    <= in_x;
      det_y    <= in_y;
      scan_idx <= '0;
    end else begin
      if (s2_valid && !s2_used && (cand_dist < best)) begin
        best    <= cand_dist;
        win_idx <= s2_idx;
        best_id <= s2_id;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx_inc;
      end
    end
  end

  assign commit_id = found ? best_id : next_ident;

  // Frame start, commit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank   <= 1'b0;
      prev_count <= '0;
      cur_count  <= '0;
      last_time  <= '0;
      next_ident <= ID_FIRST;
      prev_used  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.frame_start) begin
        cur_bank   <= ~cur_bank;
        prev_count <= (age >= TIME_W'(max_age)) ? '0 : cur_count;
        cur_count  <= '0;
        last_time  <= in_time;
        prev_used  <= '0;
      end
      if (cmd.commit) begin
        if (found) begin
          prev_used[win_idx] <= 1'b1;
        end else if ((next_ident == ID_LAST) || (next_ident == '0)) begin
          next_ident <= ID_FIRST;
        end else begin
          next_ident <= next_ident + 1'b1;
        end
        if (wr_en) begin
          cur_count <= cur_count + 1'b1;
        end
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (cmd.commit) begin
      out_id   <= commit_id;
      out_new  <= !found;
      out_full <= !wr_en;
    end
  end

  // Status to controller
  assign stat.scan_last  = (scan_idx_inc == prev_count);
  assign stat.prev_empty = (prev_count == '0);
  assign stat.out_busy   = out_valid && !out_ready;

`ifndef SYNTH
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result overwritten while stalled");
  a_cur_bound: assert property (@(posedge clk) disable iff (rst)
    (cur_count <= CNT_MAX) && (prev_count <= CNT_MAX))
    else $error("table count beyond depth");
  a_found_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && found) |-> (best < {1'b0, match_limit}))
    else $error("match not inside radius");
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result without commit");
`endif

endmodule

// ===== sv/greedy_nearest_track_id_assigner.sv =====
// Greedy nearest-neighbor track id assigner.
// Input stream (s_axis_*): tuser is the item kind, 0 frame start, 1 detection.
//   tdata carries pos_x, pos_y and time_ms. A frame start swaps the table
//   banks, ages out the previous frame and produces no result. A detection
//   scans the n live previous-frame entries, one memory read per cycle,
//   through a two-stage square/compare pipeline.
// Output stream (m_axis_*): one result per detection: target_id in tdata,
//   is_new and table_full in tuser.
// Config channel (cfg_*): index 0 match radius in mm, index 1 max age in ms.
//   Always ready; write only while the block is idle.
// Sequence: a detection with n live previous-frame entries (at most
//   MAX_TARGETS) passes through S_SCAN, S_WAIT1, S_WAIT2 and S_DONE; with
//   an empty previous table it goes straight to S_DONE. Its result is
//   committed in S_DONE and the next request is taken only after that. The
//   scan of the table memory sets the length of a detection.
// Reset: both tables empty, ids restart at 1, registers back to 300 mm and
//   500 ms. No clearing pass is needed.
// Backpressure: a result waits in the output register; the block finishes
//   the next detection's scan and holds there until the register frees.
module greedy_nearest_track_id_assigner import gtid_pkg::*; #(
  parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, time_ms
  input  logic                  s_axis_tuser,   // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // target_id
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // is_new, table_full
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  gtid_cmd_t  cmd;
  gtid_stat_t stat;
  logic       out_new, out_full;

  assign cfg_ready    = 1'b1;
  assign m_axis_tuser = {out_full, out_new};

  gtid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtid_dpath #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_x      (s_axis_tdata[POS_W-1:0]),
    .in_y      (s_axis_tdata[2*POS_W-1:POS_W]),
    .in_time   (s_axis_tdata[IN_DATA_W-1:2*POS_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_id    (m_axis_tdata),
    .out_new   (out_new),
    .out_full  (out_full)
  );

endmodule
